@@ hw/rtl/pcid_slot_allocator_lru_top_defines.svh @@
// assertion macros for the slot allocator top level
// expects clk and rst_n in scope where used
`ifndef PCID_SLOT_ALLOCATOR_LRU_TOP_DEFINES_SVH
`define PCID_SLOT_ALLOCATOR_LRU_TOP_DEFINES_SVH

// same-cycle implication
`define PCIDSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCIDSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pcidsa_pkg.sv @@
// shared constants and types for the slot allocator
// no dependencies
package pcidsa_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int ROOT_W        = 40;
    localparam int STAMP_W       = 64;
    localparam int CR3_W         = 64;
    localparam int ACTION_W      = 2;
    localparam int SLOT_W        = 3;
    localparam int TAG_W         = 12;
    localparam int KEEP_BIT      = 63;

    localparam logic [ACTION_W-1:0] ACT_ACTIVE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REUSE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_NEW    = 2'd2;

    // search token status handed from cell to cell
    typedef struct packed {
        logic vld;
        logic hit;
    } tok_flags_t;

    // slot write command broadcast to the cells
    typedef struct packed {
        logic en;
        logic load_root;
    } slot_wr_t;

endpackage

@@ hw/rtl/pcidsa_cell.sv @@
// one slot of the allocator: root tag, valid bit and use stamp
// compares the passing search token and hands it to the next cell; uses pcidsa_pkg
module pcidsa_cell #(
    parameter int NUM_SLOTS = pcidsa_pkg::NUM_SLOTS_DEF,
    parameter int CELL_IDX  = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pcidsa_pkg::ROOT_W-1:0]     req_root,
    input  pcidsa_pkg::tok_flags_t            tok_in_flags,
    input  logic [$clog2(NUM_SLOTS)-1:0]      tok_in_hit_idx,
    input  logic [$clog2(NUM_SLOTS)-1:0]      tok_in_vic_idx,
    input  logic [pcidsa_pkg::STAMP_W-1:0]    tok_in_vic_stamp,
    output pcidsa_pkg::tok_flags_t            tok_out_flags,
    output logic [$clog2(NUM_SLOTS)-1:0]      tok_out_hit_idx,
    output logic [$clog2(NUM_SLOTS)-1:0]      tok_out_vic_idx,
    output logic [pcidsa_pkg::STAMP_W-1:0]    tok_out_vic_stamp,
    input  pcidsa_pkg::slot_wr_t              wr_cmd,
    input  logic [$clog2(NUM_SLOTS)-1:0]      wr_idx,
    input  logic [pcidsa_pkg::ROOT_W-1:0]     wr_root,
    input  logic [pcidsa_pkg::STAMP_W-1:0]    wr_stamp
);
    import pcidsa_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ROOT_W-1:0]  root_reg;
    logic               valid_reg;
    logic [STAMP_W-1:0] stamp_reg;

    tok_flags_t         flags_reg,     flags_next;
    logic [IDX_W-1:0]   hit_idx_reg,   hit_idx_next;
    logic [IDX_W-1:0]   vic_idx_reg,   vic_idx_next;
    logic [STAMP_W-1:0] vic_stamp_reg, vic_stamp_next;

    logic sel;

    assign sel = wr_cmd.en && (wr_idx == MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= '0;
            valid_reg <= 1'b0;
            stamp_reg <= '0;
        end
        else if (sel)
        begin
            stamp_reg <= wr_stamp;
            if (wr_cmd.load_root)
            begin
                root_reg  <= wr_root;
                valid_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        flags_next     = tok_in_flags;
        hit_idx_next   = tok_in_hit_idx;
        vic_idx_next   = tok_in_vic_idx;
        vic_stamp_next = tok_in_vic_stamp;
        // an earlier hit passes through untouched
        if (tok_in_flags.vld && !tok_in_flags.hit)
        begin
            if (valid_reg && (root_reg == req_root))
            begin
                flags_next.hit = 1'b1;
                hit_idx_next   = MY_IDX;
            end
            else if (stamp_reg < tok_in_vic_stamp)
            begin
                vic_idx_next   = MY_IDX;
                vic_stamp_next = stamp_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else
            flags_reg <= flags_next;
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        vic_idx_reg   <= vic_idx_next;
        vic_stamp_reg <= vic_stamp_next;
    end

    assign tok_out_flags     = flags_reg;
    assign tok_out_hit_idx   = hit_idx_reg;
    assign tok_out_vic_idx   = vic_idx_reg;
    assign tok_out_vic_stamp = vic_stamp_reg;

endmodule

@@ hw/rtl/pcid_slot_allocator_lru_top.sv @@
// channel  | dir | handshake           | payload
// request  | in  | in_valid / in_stall  | root_frame
// result   | out | out_valid/ out_stall | action, slot, cr3_value
// config   | in  | cfg_wr_en           | cfg_wr_data (enable)
//
// after a request is taken, the search token walks the slot chain through the cell registers
// (the first cell reads the launch register); the chain end is then captured, and the decide
// step loads the result register
// the next request is taken the cycle after the decide cycle
// reset empties all slots, zeroes stamps and counter, and sets the enable
// a stalled result holds the decide step; the chain itself never stalls
//
// top level of the slot allocator: controller, stamp counter and result register
// depends on pcidsa_pkg, pcidsa_cell and the defines header
`include "pcid_slot_allocator_lru_top_defines.svh"

module pcid_slot_allocator_lru_top #(
    parameter int NUM_SLOTS = pcidsa_pkg::NUM_SLOTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pcidsa_pkg::ROOT_W-1:0]      root_frame,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pcidsa_pkg::ACTION_W-1:0]    action,
    output logic [pcidsa_pkg::SLOT_W-1:0]      slot,
    output logic [pcidsa_pkg::CR3_W-1:0]       cr3_value
);
    import pcidsa_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic               en_reg;
    logic               start_reg;
    logic [ROOT_W-1:0]  req_root_reg;
    logic [STAMP_W-1:0] stamp_cnt_reg;
    logic [IDX_W-1:0]   active_reg;

    logic               fin_hit_reg;
    logic [IDX_W-1:0]   fin_hit_idx_reg;
    logic [IDX_W-1:0]   fin_vic_idx_reg;

    logic                out_valid_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CR3_W-1:0]    cr3_reg;

    tok_flags_t         tok_flags [NUM_SLOTS+1];
    logic [IDX_W-1:0]   tok_hit_idx [NUM_SLOTS+1];
    logic [IDX_W-1:0]   tok_vic_idx [NUM_SLOTS+1];
    logic [STAMP_W-1:0] tok_vic_stamp [NUM_SLOTS+1];
    logic [NUM_SLOTS:0] tok_vld_vec;

    logic in_acc;
    logic out_free;
    logic decide;

    slot_wr_t            wr_cmd;
    logic [IDX_W-1:0]    dec_idx;
    logic [ACTION_W-1:0] dec_action;
    logic                dec_keep;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign decide   = (state_reg == ST_DECIDE) && out_free;

    // token launch into the head of the chain
    assign tok_flags[0]     = '{vld: start_reg, hit: 1'b0};
    assign tok_hit_idx[0]   = '0;
    assign tok_vic_idx[0]   = '0;
    assign tok_vic_stamp[0] = '1;

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        pcidsa_cell #(
            .NUM_SLOTS (NUM_SLOTS),
            .CELL_IDX  (g)
        ) u_cell (
            .clk               (clk),
            .rst_n             (rst_n),
            .req_root          (req_root_reg),
            .tok_in_flags      (tok_flags[g]),
            .tok_in_hit_idx    (tok_hit_idx[g]),
            .tok_in_vic_idx    (tok_vic_idx[g]),
            .tok_in_vic_stamp  (tok_vic_stamp[g]),
            .tok_out_flags     (tok_flags[g+1]),
            .tok_out_hit_idx   (tok_hit_idx[g+1]),
            .tok_out_vic_idx   (tok_vic_idx[g+1]),
            .tok_out_vic_stamp (tok_vic_stamp[g+1]),
            .wr_cmd            (wr_cmd),
            .wr_idx            (dec_idx),
            .wr_root           (req_root_reg),
            .wr_stamp          (stamp_cnt_reg)
        );
    end

    for (genvar v = 0; v <= NUM_SLOTS; v++)
    begin : g_vld
        assign tok_vld_vec[v] = tok_flags[v].vld;
    end

    // decide: enable off reloads slot zero, hit stays or reuses, miss takes the victim
    always_comb
    begin
        wr_cmd     = '0;
        dec_idx    = fin_vic_idx_reg;
        dec_action = ACT_NEW;
        dec_keep   = 1'b0;
        if (!en_reg)
        begin
            dec_idx = '0;
        end
        else if (fin_hit_reg)
        begin
            dec_idx = fin_hit_idx_reg;
            if (fin_hit_idx_reg == active_reg)
                dec_action = ACT_ACTIVE;
            else
            begin
                dec_action = ACT_REUSE;
                dec_keep   = 1'b1;
            end
        end
        if (decide && (dec_action != ACT_ACTIVE))
        begin
            wr_cmd.en        = 1'b1;
            wr_cmd.load_root = (dec_action == ACT_NEW);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tok_flags[NUM_SLOTS].vld)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            en_reg        <= 1'b1;
            start_reg     <= 1'b0;
            stamp_cnt_reg <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_acc;
            if (cfg_wr_en)
                en_reg <= cfg_wr_data;
            if (wr_cmd.en)
            begin
                stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
                active_reg    <= dec_idx;
            end
            if (decide)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            req_root_reg <= root_frame;
        if ((state_reg == ST_SCAN) && tok_flags[NUM_SLOTS].vld)
        begin
            fin_hit_reg     <= tok_flags[NUM_SLOTS].hit;
            fin_hit_idx_reg <= tok_hit_idx[NUM_SLOTS];
            fin_vic_idx_reg <= tok_vic_idx[NUM_SLOTS];
        end
        if (decide)
        begin
            action_reg <= dec_action;
            slot_reg   <= SLOT_W'(dec_idx);
            if (dec_action == ACT_ACTIVE)
                cr3_reg <= '0;
            else
                cr3_reg <= {dec_keep, {(KEEP_BIT - ROOT_W - TAG_W){1'b0}},
                            req_root_reg, TAG_W'(dec_idx)};
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign slot      = slot_reg;
    assign cr3_value = cr3_reg;

    `PCIDSA_ASSERT_NOW(a_one_token, 1'b1, ($countones(tok_vld_vec) <= 1), "two search tokens")
    `PCIDSA_ASSERT_NOW(a_accept_empty, in_acc, (tok_vld_vec == '0), "request taken mid search")
    `PCIDSA_ASSERT_NEXT(a_stamp_step, wr_cmd.en, (stamp_cnt_reg == $past(stamp_cnt_reg) + 64'd1), "stamp stuck")

endmodule
